>>> hdl/hex_string_to_u64_parser_top_defines.svh
`ifndef HEX_STRING_TO_U64_PARSER_TOP_DEFINES_SVH
`define HEX_STRING_TO_U64_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define HSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hsp_pkg.sv
`default_nettype none

package hsp_pkg;

    localparam int SYM_W      = 8;
    localparam int VALUE_W    = 64;
    localparam int NIB_W      = 4;
    localparam int MAX_DIGITS = 16;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [SYM_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [SYM_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [SYM_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [SYM_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [NIB_W-1:0] LETTER_OFS = 4'd9;

    typedef enum logic [2:0] {
        KIND_NUL   = 3'd0,
        KIND_ZERO  = 3'd1,
        KIND_HEX   = 3'd2,
        KIND_X     = 3'd3,
        KIND_BAD   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [NIB_W-1:0]  nib;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

>>> hdl/hex_string_to_u64_parser_top.sv
// ASCII hex string to 64-bit unsigned parser
// input channel: i_valid / o_stall carry one character request in i_symbol;
// a NUL character ends the string, an optional 0x or 0X prefix is skipped
// output channel: o_valid / i_stall carry one result per string, o_value
// with the digits taken and o_ok set when the string was a valid hex number
// throughput: one character per cycle on the input channel while o_stall is low
// a NUL request reaches o_valid through the front register, the
// two-entry queue and the back output register
// the front classifies characters and fills the queue; the back walks the
// prefix/digit state and owns the output register
// when the receiver stalls, the back keeps taking non-NUL characters; a NUL
// waits in the queue, and once the queue and front register fill, o_stall
// rises
// reset (synchronous, active low) empties the queue, drops any pending
// result and returns the parser to string start
`default_nettype none

`include "hex_string_to_u64_parser_top_defines.svh"

module hex_string_to_u64_parser_top
    import hsp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SYM_W-1:0]    i_symbol,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [VALUE_W-1:0]       o_value,
    output logic                     o_ok
);

    t_qstat w_qstat;
    t_req   w_push_req;
    t_req   w_head;
    logic   w_push;
    logic   w_pop;

    hsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_symbol (i_symbol),
        .o_stall  (o_stall),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_req    (w_push_req)
    );

    hsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .i_pop   (w_pop),
        .o_qstat (w_qstat),
        .o_head  (w_head)
    );

    hsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_value (o_value),
        .o_ok    (o_ok)
    );

    `HSP_ASSERT_NEXT(a_nul_gives_result, i_clk, i_rst_n, w_pop && w_head.kind == KIND_NUL, o_valid, "string end popped without a result")
    `HSP_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, w_qstat.empty, !w_pop, "pop from empty queue")
    `HSP_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, w_qstat.full, !w_push, "push into full queue")

endmodule

`default_nettype wire

>>> hdl/hsp_front.sv
`default_nettype none

module hsp_front
    import hsp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [SYM_W-1:0] i_symbol,
    output logic                  o_stall,
    input  wire t_qstat           i_qstat,
    output logic                  o_push,
    output t_req                  o_req
);

    logic r_valid;
    logic n_valid;
    t_req r_req;
    t_req n_req;
    logic w_accept;

    assign o_stall  = r_valid && i_qstat.full;
    assign o_push   = r_valid && !i_qstat.full;
    assign o_req    = r_req;
    assign w_accept = i_valid && !o_stall;

    // classify the character
    always_comb begin
        n_req = r_req;
        if (w_accept) begin
            n_req.nib = i_symbol[NIB_W-1:0];
            if (i_symbol == CH_NUL) begin
                n_req.kind = KIND_NUL;
            end else if (i_symbol == CH_ZERO) begin
                n_req.kind = KIND_ZERO;
            end else if (i_symbol > CH_ZERO && i_symbol <= CH_NINE) begin
                n_req.kind = KIND_HEX;
            end else if ((i_symbol >= CH_UP_A && i_symbol <= CH_UP_F) ||
                         (i_symbol >= CH_LO_A && i_symbol <= CH_LO_F)) begin
                n_req.kind = KIND_HEX;
                n_req.nib  = i_symbol[NIB_W-1:0] + LETTER_OFS;
            end else if (i_symbol == CH_UP_X || i_symbol == CH_LO_X) begin
                n_req.kind = KIND_X;
            end else begin
                n_req.kind = KIND_BAD;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
    end

endmodule

`default_nettype wire

>>> hdl/hsp_queue.sv
`default_nettype none

module hsp_queue
    import hsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_req  i_req,
    input  wire logic  i_pop,
    output t_qstat     o_qstat,
    output t_req       o_head
);

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hsp_back.sv
`default_nettype none

module hsp_back
    import hsp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_qstat        i_qstat,
    input  wire t_req          i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_ok
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic [VALUE_W-1:0]  r_acc;
    logic [VALUE_W-1:0]  n_acc;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_stopped;
    logic                n_stopped;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [VALUE_W-1:0]  n_out_value;
    logic                r_out_ok;
    logic                n_out_ok;
    logic                w_out_free;
    logic                w_take;
    logic                w_digit;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = !i_qstat.empty && (i_head.kind != KIND_NUL || w_out_free);
    assign w_digit    = (i_head.kind == KIND_ZERO) || (i_head.kind == KIND_HEX);
    assign o_valid    = r_out_valid;
    assign o_value    = r_out_value;
    assign o_ok       = r_out_ok;

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_count     = r_count;
        n_stopped   = r_stopped;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        n_out_ok    = r_out_ok;
        w_take      = 1'b0;
        if (o_pop) begin
            if (i_head.kind == KIND_NUL) begin
                n_out_valid = 1'b1;
                n_out_value = r_acc;
                n_out_ok    = (r_count != '0) && !r_stopped;
                n_phase     = PH_START;
                n_acc       = '0;
                n_count     = '0;
                n_stopped   = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_START: begin
                        n_phase = (i_head.kind == KIND_ZERO) ? PH_ZERO : PH_DIGITS;
                        w_take  = 1'b1;
                    end
                    PH_ZERO: begin
                        n_phase = PH_DIGITS;
                        if (i_head.kind == KIND_X) begin
                            // prefix drops the leading zero
                            n_acc   = '0;
                            n_count = '0;
                        end else begin
                            w_take = 1'b1;
                        end
                    end
                    default: begin
                        w_take = 1'b1;
                    end
                endcase
                if (w_take && !r_stopped) begin
                    if (w_digit && r_count < CNT_W'(MAX_DIGITS)) begin
                        n_acc   = {r_acc[VALUE_W-NIB_W-1:0], i_head.nib};
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_stopped = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_acc       <= '0;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_ok    <= n_out_ok;
    end

endmodule

`default_nettype wire
